FILE: sv/afa_pkg.sv
// ----------------------------------------------------------------------------
// afa_pkg: shared types and helpers for the affine form arithmetic unit
// Holds the request and result structs, the opcode codes, the operation
// classes used between the front and back parts, and saturation helpers.
// ----------------------------------------------------------------------------
package afa_pkg;

    localparam int DEFAULT_FRACTION_BITS = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int RAD_W = 48;

    // Opcode codes as they arrive on the request channel.
    typedef enum logic [2:0] {
        OPC_ADD   = 3'd0,
        OPC_SUB   = 3'd1,
        OPC_NEG   = 3'd2,
        OPC_SCALE = 3'd3,
        OPC_MUL   = 3'd4
    } opcode_t;

    // Operation class decided by the front part.
    typedef enum logic [2:0] {
        K_ADD,
        K_SUB,
        K_NEG,
        K_SCALE,
        K_MUL,
        K_NONE
    } op_kind_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] center_a;
        logic [30:0]        err_a;
        logic signed [31:0] dev_a;
        logic signed [31:0] center_b;
        logic [30:0]        err_b;
        logic signed [31:0] dev_b;
        logic               last_term;
    } afa_in_t;

    typedef struct packed {
        logic signed [31:0] dev_out;
        logic signed [31:0] center_out;
        logic signed [31:0] err_out;
        logic               last_out;
    } afa_out_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        op_kind_t kind;
        afa_in_t  data;
    } afa_entry_t;

    localparam logic signed [65:0] SAT32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT32_MIN = -66'sd2147483648;
    localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > SAT32_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < SAT32_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Saturate a 65-bit signed sum to 64 bits.
    function automatic logic signed [63:0] sat64(input logic signed [64:0] x);
        logic signed [63:0] r;
        if (x[64] != x[63])
        begin
            r = x[64] ? INT64_MIN : INT64_MAX;
        end
        else
        begin
            r = x[63:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/afa_front.sv
// ----------------------------------------------------------------------------
// afa_front: request intake and classification
// Registers each incoming request, classifies its opcode and hands it to the
// queue as soon as the queue has room.
// ----------------------------------------------------------------------------
module afa_front
    import afa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  afa_in_t    in_data,
    output logic       push,
    output afa_entry_t push_entry,
    input  logic       queue_ready
);

    logic       valid_reg;
    logic       valid_next;
    afa_entry_t entry_reg;
    op_kind_t   kind;
    logic       accept;

    // Opcode classification.
    always_comb
    begin
        unique case (in_data.opcode)
            OPC_ADD:   kind = K_ADD;
            OPC_SUB:   kind = K_SUB;
            OPC_NEG:   kind = K_NEG;
            OPC_SCALE: kind = K_SCALE;
            OPC_MUL:   kind = K_MUL;
            default:   kind = K_NONE;
        endcase
    end

    // The holding register drains into the queue whenever it has room.
    assign push       = valid_reg && queue_ready;
    assign in_stall   = valid_reg && !queue_ready;
    assign accept     = in_valid && !in_stall;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.kind <= kind;
            entry_reg.data <= in_data;
        end
    end

endmodule

FILE: sv/afa_queue.sv
// ----------------------------------------------------------------------------
// afa_queue: short request queue between front and back
// A small circular buffer that lets the front and back parts stall
// independently of each other.
// ----------------------------------------------------------------------------
module afa_queue
    import afa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  afa_entry_t push_entry,
    output logic       ready,
    output logic       not_empty,
    input  logic       pop,
    output afa_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    afa_entry_t       entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign ready     = count_reg != (PTR_W + 1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_entry = entries[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/afa_back.sv
// ----------------------------------------------------------------------------
// afa_back: execution pipeline
// Five stages: products, shifts and accumulation, radius partial products
// and center, radius product assembly, and the error sum into the result
// register. The whole pipeline advances unless the result is held.
// ----------------------------------------------------------------------------
module afa_back
    import afa_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fast_multiply,
    input  logic       in_avail,
    input  afa_entry_t in_entry,
    output logic       take,
    output logic       out_valid,
    input  logic       out_stall,
    output afa_out_t   out_data
);

    localparam logic [RAD_W-1:0] RAD_MAX = '1;

    logic en;

    // Stage 1 registers.
    logic               s1_v_reg;
    op_kind_t           s1_kind_reg;
    logic               s1_last_reg;
    logic signed [63:0] s1_pdd_reg;
    logic signed [63:0] s1_pcbda_reg;
    logic signed [63:0] s1_pcadb_reg;
    logic signed [63:0] s1_pcacb_reg;
    logic [62:0]        s1_peacb_reg;
    logic [62:0]        s1_pebca_reg;
    logic [31:0]        s1_absda_reg;
    logic [31:0]        s1_absdb_reg;
    logic [30:0]        s1_ea_reg;
    logic [30:0]        s1_eb_reg;
    logic signed [31:0] s1_sdev_reg;
    logic signed [31:0] s1_scen_reg;
    logic signed [31:0] s1_serr_reg;

    // Accumulators.
    logic signed [63:0] ps_reg;
    logic signed [63:0] ps_next;
    logic signed [63:0] aps_reg;
    logic signed [63:0] aps_next;
    logic [RAD_W-1:0]   rada_reg;
    logic [RAD_W-1:0]   rada_next;
    logic [RAD_W-1:0]   radb_reg;
    logic [RAD_W-1:0]   radb_next;

    // Stage 2 registers.
    logic               s2_v_reg;
    logic               s2_mul_last_reg;
    logic signed [31:0] s2_dev_reg;
    logic signed [31:0] s2_cen_reg;
    logic signed [31:0] s2_err_reg;
    logic signed [63:0] s2_cenmul_reg;
    logic [63:0]        s2_e1_reg;
    logic [RAD_W:0]     s2_ra_reg;
    logic [RAD_W:0]     s2_rb_reg;
    logic signed [63:0] s2_ps_reg;
    logic signed [63:0] s2_aps_reg;

    // Stage 3 registers.
    logic               s3_v_reg;
    logic               s3_mul_last_reg;
    logic signed [31:0] s3_dev_reg;
    logic signed [31:0] s3_cen_reg;
    logic signed [31:0] s3_err_reg;
    logic signed [31:0] s3_cenmul_reg;
    logic [63:0]        s3_e1_reg;
    logic signed [63:0] s3_aps_reg;
    logic [33:0]        s3_hh_reg;
    logic [48:0]        s3_hl_reg;
    logic [48:0]        s3_lh_reg;
    logic [63:0]        s3_ll_reg;

    // Stage 4 registers.
    logic               s4_v_reg;
    logic               s4_mul_last_reg;
    logic signed [31:0] s4_dev_reg;
    logic signed [31:0] s4_cen_reg;
    logic signed [31:0] s4_err_reg;
    logic signed [31:0] s4_cenmul_reg;
    logic [63:0]        s4_e1_reg;
    logic signed [63:0] s4_aps_reg;
    logic [63:0]        s4_rp_reg;

    // Last flag that travels with the valid bits.
    logic s2_last_reg;
    logic s3_last_reg;
    logic s4_last_reg;

    // Result register.
    logic     out_v_reg;
    afa_out_t out_reg;

    // Stage 1 combinational signals.
    logic signed [31:0] ca, cb, da, db;
    logic [31:0]        abs_ca, abs_cb, abs_da, abs_db;
    logic signed [65:0] xa, xb, xca, xcb, xsum_e;
    logic signed [31:0] sdev, scen, serr;

    // Stage 2 combinational signals.
    logic signed [63:0] pdd_sh, pcbda_sh, pcadb_sh, pcacb_sh;
    logic [63:0]        abs_pdd;
    logic [64:0]        aps_sum;
    logic signed [63:0] ps_new, aps_new;
    logic [RAD_W:0]     rada_sum, radb_sum;
    logic [RAD_W-1:0]   rada_new, radb_new;
    logic signed [31:0] dev2, cen2, err2;

    // Stage 4 and result combinational signals.
    logic [97:0]        full;
    logic [64:0]        e2_sum;
    logic [63:0]        e2;
    logic signed [65:0] err_m;
    afa_out_t           res;

    assign en        = !out_v_reg || !out_stall;
    assign take      = en && in_avail;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // Stage 1: operands, absolute values, products and the simple operations.
    always_comb
    begin
        ca     = in_entry.data.center_a;
        cb     = in_entry.data.center_b;
        da     = in_entry.data.dev_a;
        db     = in_entry.data.dev_b;
        abs_ca = ca[31] ? (~ca + 1'b1) : ca;
        abs_cb = cb[31] ? (~cb + 1'b1) : cb;
        abs_da = da[31] ? (~da + 1'b1) : da;
        abs_db = db[31] ? (~db + 1'b1) : db;
        xa     = 66'(da);
        xb     = 66'(db);
        xca    = 66'(ca);
        xcb    = 66'(cb);
        xsum_e = $signed({35'b0, in_entry.data.err_a}) + $signed({35'b0, in_entry.data.err_b});
        unique case (in_entry.kind)
            K_ADD:
            begin
                sdev = sat32(xa + xb);
                scen = sat32(xca + xcb);
                serr = sat32(xsum_e);
            end
            K_SUB:
            begin
                sdev = sat32(xa - xb);
                scen = sat32(xca - xcb);
                serr = sat32(xsum_e);
            end
            K_NEG:
            begin
                sdev = sat32(-xa);
                scen = sat32(-xca);
                serr = $signed({1'b0, in_entry.data.err_a});
            end
            default:
            begin
                sdev = '0;
                scen = '0;
                serr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg  <= in_entry.kind;
            s1_last_reg  <= in_entry.data.last_term;
            s1_pdd_reg   <= 64'(da) * 64'(db);
            s1_pcbda_reg <= 64'(cb) * 64'(da);
            s1_pcadb_reg <= 64'(ca) * 64'(db);
            s1_pcacb_reg <= 64'(ca) * 64'(cb);
            s1_peacb_reg <= 63'(in_entry.data.err_a) * 63'(abs_cb);
            s1_pebca_reg <= 63'(in_entry.data.err_b) * 63'(abs_ca);
            s1_absda_reg <= abs_da;
            s1_absdb_reg <= abs_db;
            s1_ea_reg    <= in_entry.data.err_a;
            s1_eb_reg    <= in_entry.data.err_b;
            s1_sdev_reg  <= sdev;
            s1_scen_reg  <= scen;
            s1_serr_reg  <= serr;
        end
    end

    // Stage 2: shifted products, saturating accumulation and radii.
    always_comb
    begin
        pdd_sh   = s1_pdd_reg >>> FRACTION_BITS;
        pcbda_sh = s1_pcbda_reg >>> FRACTION_BITS;
        pcadb_sh = s1_pcadb_reg >>> FRACTION_BITS;
        pcacb_sh = s1_pcacb_reg >>> FRACTION_BITS;
        abs_pdd  = s1_pdd_reg[63] ? (~s1_pdd_reg + 1'b1) : s1_pdd_reg;
        ps_new   = sat64(65'(ps_reg) + 65'(pdd_sh));
        aps_sum  = {1'b0, aps_reg} + {1'b0, (abs_pdd >> FRACTION_BITS)};
        aps_new  = (aps_sum[64:63] != 2'b00) ? INT64_MAX : aps_sum[63:0];
        rada_sum = {1'b0, rada_reg} + (RAD_W + 1)'(s1_absda_reg);
        radb_sum = {1'b0, radb_reg} + (RAD_W + 1)'(s1_absdb_reg);
        rada_new = rada_sum[RAD_W] ? RAD_MAX : rada_sum[RAD_W-1:0];
        radb_new = radb_sum[RAD_W] ? RAD_MAX : radb_sum[RAD_W-1:0];

        ps_next   = ps_reg;
        aps_next  = aps_reg;
        rada_next = rada_reg;
        radb_next = radb_reg;
        if (s1_v_reg && s1_last_reg)
        begin
            ps_next   = '0;
            aps_next  = '0;
            rada_next = '0;
            radb_next = '0;
        end
        else if (s1_v_reg && s1_kind_reg == K_MUL)
        begin
            ps_next   = ps_new;
            aps_next  = aps_new;
            rada_next = rada_new;
            radb_next = radb_new;
        end

        unique case (s1_kind_reg)
            K_ADD, K_SUB, K_NEG:
            begin
                dev2 = s1_sdev_reg;
                cen2 = s1_scen_reg;
                err2 = s1_serr_reg;
            end
            K_SCALE:
            begin
                dev2 = sat32(66'(pcbda_sh));
                cen2 = sat32(66'(pcacb_sh));
                err2 = sat32($signed({3'b0, (s1_peacb_reg >> FRACTION_BITS)}));
            end
            K_MUL:
            begin
                dev2 = sat32(66'(pcbda_sh) + 66'(pcadb_sh));
                cen2 = '0;
                err2 = '0;
            end
            default:
            begin
                dev2 = '0;
                cen2 = '0;
                err2 = '0;
            end
        endcase
        if (!s1_last_reg)
        begin
            cen2 = '0;
            err2 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg   <= '0;
            aps_reg  <= '0;
            rada_reg <= '0;
            radb_reg <= '0;
        end
        else if (en)
        begin
            ps_reg   <= ps_next;
            aps_reg  <= aps_next;
            rada_reg <= rada_next;
            radb_reg <= radb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mul_last_reg <= (s1_kind_reg == K_MUL) && s1_last_reg;
            s2_dev_reg      <= dev2;
            s2_cen_reg      <= cen2;
            s2_err_reg      <= err2;
            s2_cenmul_reg   <= pcacb_sh;
            s2_e1_reg       <= 64'(s1_pebca_reg >> FRACTION_BITS)
                               + 64'(s1_peacb_reg >> FRACTION_BITS);
            s2_ra_reg       <= (RAD_W + 1)'(s1_ea_reg) + (RAD_W + 1)'(rada_new);
            s2_rb_reg       <= (RAD_W + 1)'(s1_eb_reg) + (RAD_W + 1)'(radb_new);
            s2_ps_reg       <= ps_new;
            s2_aps_reg      <= aps_new;
        end
    end

    // Stage 3: radius partial products and the multiply center.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_mul_last_reg <= s2_mul_last_reg;
            s3_dev_reg      <= s2_dev_reg;
            s3_cen_reg      <= s2_cen_reg;
            s3_err_reg      <= s2_err_reg;
            s3_cenmul_reg   <= sat32(66'(s2_cenmul_reg)
                               + (fast_multiply ? 66'sd0 : 66'(s2_ps_reg >>> 1)));
            s3_e1_reg       <= s2_e1_reg;
            s3_aps_reg      <= s2_aps_reg;
            s3_hh_reg       <= 34'(s2_ra_reg[RAD_W:32]) * 34'(s2_rb_reg[RAD_W:32]);
            s3_hl_reg       <= 49'(s2_ra_reg[RAD_W:32]) * 49'(s2_rb_reg[31:0]);
            s3_lh_reg       <= 49'(s2_ra_reg[31:0]) * 49'(s2_rb_reg[RAD_W:32]);
            s3_ll_reg       <= 64'(s2_ra_reg[31:0]) * 64'(s2_rb_reg[31:0]);
        end
    end

    // Stage 4: radius product; anything at or above 2^64 saturates.
    assign full = (98'(s3_hh_reg) << 64) + (98'(s3_hl_reg) << 32)
                  + (98'(s3_lh_reg) << 32) + 98'(s3_ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_mul_last_reg <= s3_mul_last_reg;
            s4_dev_reg      <= s3_dev_reg;
            s4_cen_reg      <= s3_cen_reg;
            s4_err_reg      <= s3_err_reg;
            s4_cenmul_reg   <= s3_cenmul_reg;
            s4_e1_reg       <= s3_e1_reg;
            s4_aps_reg      <= s3_aps_reg;
            s4_rp_reg       <= (full[97:64] != '0) ? INT64_MAX
                                                   : (full[63:0] >> FRACTION_BITS);
        end
    end

    // Result: error sum for multiply, then the output register.
    always_comb
    begin
        e2_sum = {1'b0, s4_e1_reg} + {1'b0, s4_rp_reg};
        e2     = (e2_sum[64:63] != 2'b00) ? INT64_MAX : e2_sum[63:0];
        err_m  = $signed({2'b0, e2})
                 - (fast_multiply ? 66'sd0 : 66'(s4_aps_reg >>> 1));
        res.dev_out    = s4_dev_reg;
        res.center_out = s4_cen_reg;
        res.err_out    = s4_err_reg;
        res.last_out   = s4_last_reg;
        if (s4_mul_last_reg)
        begin
            res.center_out = s4_cenmul_reg;
            res.err_out    = sat32(err_m);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= res;
        end
    end

    // Valid bits and the last flag advance together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            s2_last_reg <= 1'b0;
            s3_last_reg <= 1'b0;
            s4_last_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= in_avail;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            out_v_reg   <= s4_v_reg;
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

endmodule

FILE: sv/affine_form_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// affine_form_arithmetic_unit: streaming affine form arithmetic
// Adds, subtracts, negates, scales or multiplies two affine forms, one noise
// term per request, with a front intake, a short queue and an execution
// pipeline.
// ----------------------------------------------------------------------------
// The unit takes one request per clock when in_stall is low and returns one
// result per request, in order. A request passes from acceptance through
// the intake register, the queue and the execution pipeline into the result
// register. The pipeline depth is set by the product of the 49-bit radii,
// which is split at bit 32 into partial products.
// The multiply accumulators are cleared by any request marked as the last
// noise term. Write fast_multiply only while the unit is idle.
module affine_form_arithmetic_unit
    import afa_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  afa_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output afa_out_t out_data,
    input  logic     cfg_we,
    input  logic     cfg_data
);

    logic       fast_reg;
    logic       push;
    afa_entry_t push_entry;
    logic       queue_ready;
    logic       queue_not_empty;
    logic       take;
    afa_entry_t pop_entry;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            fast_reg <= cfg_data;
        end
    end

    afa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push       (push),
        .push_entry (push_entry),
        .queue_ready(queue_ready)
    );

    afa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .ready     (queue_ready),
        .not_empty (queue_not_empty),
        .pop       (take),
        .pop_entry (pop_entry)
    );

    afa_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fast_multiply(fast_reg),
        .in_avail     (queue_not_empty),
        .in_entry     (pop_entry),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule
